// ----- rtl/tcc_pkg.sv -----
// shared types, constants and codes of the text console cursor control block
package tcc_pkg;

	localparam int MAX_COLUMNS = 256;
	localparam int MAX_ROWS    = 128;
	localparam int TAB_STOP    = 8;

	// opcodes of an input transaction
	localparam logic OP_PUT   = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	// control characters
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// configuration register indexes
	localparam logic [1:0] REG_COLUMNS = 2'd0;
	localparam logic [1:0] REG_ROWS    = 2'd1;
	localparam logic [1:0] REG_FG      = 2'd2;
	localparam logic [1:0] REG_BG      = 2'd3;

	// configuration reset values
	localparam logic [8:0]  COLUMNS_RESET = 9'd80;
	localparam logic [7:0]  ROWS_RESET    = 8'd25;
	localparam logic [31:0] FG_RESET      = 32'h00FF_FFFF;
	localparam logic [31:0] BG_RESET      = 32'h0000_0000;

	typedef enum logic [1:0] {
		KIND_DRAW   = 2'd0,
		KIND_SCROLL = 2'd1,
		KIND_CLEAR  = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		logic [8:0]  columns;
		logic [7:0]  rows;
		logic [31:0] fg;
		logic [31:0] bg;
	} config_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  col;
		logic [6:0]  row;
		logic [7:0]  glyph;
		logic [31:0] fg;
		logic [31:0] bg;
		logic        last;
	} result_t;

endpackage

// ----- rtl/tcc_cursor.sv -----
// cursor state and per-character command generation
module tcc_cursor import tcc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  config_t    cfg,
	input  logic       item_go,
	input  logic       item_opcode,
	input  logic [7:0] item_char,
	output result_t    res0,
	output result_t    res1,
	output logic [1:0] res_count
);

	logic [7:0] cur_col_q;
	logic [6:0] cur_row_q;

	logic [8:0] cols;
	logic [7:0] rows;
	logic [8:0] x;
	logic [8:0] nx;
	logic [7:0] ny;
	logic [7:0] draw_col;
	logic [7:0] draw_glyph;
	logic       draw;
	logic       scroll;
	logic [7:0] next_col;
	logic [6:0] next_row;
	result_t    draw_res;
	result_t    aux_res;

	always_comb begin
		if (cfg.columns == 9'd0) begin
			cols = 9'd1;
		end else if (cfg.columns > 9'(MAX_COLUMNS)) begin
			cols = 9'(MAX_COLUMNS);
		end else begin
			cols = cfg.columns;
		end
		if (cfg.rows == 8'd0) begin
			rows = 8'd1;
		end else if (cfg.rows > 8'(MAX_ROWS)) begin
			rows = 8'(MAX_ROWS);
		end else begin
			rows = cfg.rows;
		end
	end

	always_comb begin
		x          = {1'b0, cur_col_q};
		nx         = x;
		ny         = {1'b0, cur_row_q};
		draw       = 1'b0;
		draw_col   = cur_col_q;
		draw_glyph = item_char;
		unique case (item_char)
			CH_LF: begin
				nx = 9'd0;
				ny = ny + 8'd1;
			end
			CH_CR: begin
				nx = 9'd0;
			end
			CH_TAB: begin
				nx = x + 9'(TAB_STOP) - (x % 9'(TAB_STOP));
			end
			CH_BS: begin
				if (x != 9'd0) begin
					nx         = x - 9'd1;
					draw       = 1'b1;
					draw_col   = nx[7:0];
					draw_glyph = CH_SPACE;
				end
			end
			default: begin
				draw = 1'b1;
				nx   = x + 9'd1;
			end
		endcase
		// wrap past the right edge
		if (nx >= cols) begin
			nx = 9'd0;
			ny = ny + 8'd1;
		end
		// scroll past the bottom, cursor pinned to last row
		scroll = 1'b0;
		if (ny >= rows) begin
			scroll = 1'b1;
			ny     = rows - 8'd1;
		end
		next_col = nx[7:0];
		next_row = ny[6:0];
	end

	always_comb begin
		draw_res.kind  = KIND_DRAW;
		draw_res.col   = draw_col;
		draw_res.row   = cur_row_q;
		draw_res.glyph = draw_glyph;
		draw_res.fg    = cfg.fg;
		draw_res.bg    = cfg.bg;
		draw_res.last  = !scroll;

		aux_res.kind  = (item_opcode == OP_CLEAR) ? KIND_CLEAR : KIND_SCROLL;
		aux_res.col   = 8'd0;
		aux_res.row   = 7'd0;
		aux_res.glyph = 8'd0;
		aux_res.fg    = 32'd0;
		aux_res.bg    = cfg.bg;
		aux_res.last  = 1'b1;

		if (item_opcode == OP_CLEAR) begin
			res0      = aux_res;
			res1      = aux_res;
			res_count = 2'd1;
		end else if (draw) begin
			res0      = draw_res;
			res1      = aux_res;
			res_count = {scroll, !scroll};
		end else begin
			res0      = aux_res;
			res1      = aux_res;
			res_count = {1'b0, scroll};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q <= 8'd0;
			cur_row_q <= 7'd0;
		end else if (item_go) begin
			if (item_opcode == OP_CLEAR) begin
				cur_col_q <= 8'd0;
				cur_row_q <= 7'd0;
			end else begin
				cur_col_q <= next_col;
				cur_row_q <= next_row;
			end
		end
	end

endmodule

// ----- rtl/tcc_out_fifo.sv -----
// four-entry result queue taking up to two results per cycle
module tcc_out_fifo import tcc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push_count,
	input  result_t    push0,
	input  result_t    push1,
	input  logic       pop,
	output result_t    head,
	output logic       head_valid,
	output logic       room2
);

	localparam int DEPTH = 4;
	localparam int AW    = $clog2(DEPTH);

	result_t        mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [AW:0]    count_q;

	assign head       = mem_q[rd_ptr_q];
	assign head_valid = (count_q != '0);
	assign room2      = (count_q <= (AW+1)'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_count != 2'd0) begin
			mem_q[wr_ptr_q] <= push0;
		end
		if (push_count == 2'd2) begin
			mem_q[wr_ptr_q + AW'(1)] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + AW'(push_count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			count_q <= count_q + (AW+1)'(push_count) - (AW+1)'(pop);
		end
	end

endmodule

// ----- rtl/text_console_cursor_control.sv -----
// top level of the text console cursor control block
// path: an input transaction is held in the input register stage and then enters the result
//   queue, from whose head the master side takes its commands
// throughput: one input transaction per cycle while each yields at most one command and the master
//   side takes them; the staged item waits while the four-entry queue holds more than two, so a
//   character that also scrolls yields two commands
// reset: cursor homed, registers back to 80 columns, 25 rows, white on black, queue empty
module text_console_cursor_control import tcc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic [0:0]  s_tuser,   // [0] opcode
	// command stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] cell_column, [14:8] cell_row, [22:15] glyph_code,
	// [54:23] draw_fg, [86:55] draw_bg, [87] zero
	output logic [87:0] m_tdata,
	output logic [1:0]  m_tuser,   // [1:0] command_kind
	output logic        m_tlast,   // last_of_run
	// configuration writes
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	config_t    cfg_q;

	// input register stage
	logic       item_valid_s1;
	logic       item_opcode_s1;
	logic [7:0] item_char_s1;

	logic       item_go;
	logic       room2;
	logic [1:0] res_count;
	logic [1:0] push_count;
	result_t    res0;
	result_t    res1;
	result_t    head;
	logic       head_valid;

	// configuration registers; the user must write them only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.columns <= COLUMNS_RESET;
			cfg_q.rows    <= ROWS_RESET;
			cfg_q.fg      <= FG_RESET;
			cfg_q.bg      <= BG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COLUMNS: cfg_q.columns <= cfg_data[8:0];
				REG_ROWS:    cfg_q.rows    <= cfg_data[7:0];
				REG_FG:      cfg_q.fg      <= cfg_data;
				REG_BG:      cfg_q.bg      <= cfg_data;
			endcase
		end
	end

	// the staged item moves on once the queue has room for two commands
	assign item_go  = item_valid_s1 && room2;
	assign s_tready = !item_valid_s1 || room2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			item_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_opcode_s1 <= s_tuser[0];
			item_char_s1   <= s_tdata;
		end
	end

	// cursor update and command generation
	tcc_cursor u_cursor (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.item_go     (item_go),
		.item_opcode (item_opcode_s1),
		.item_char   (item_char_s1),
		.res0        (res0),
		.res1        (res1),
		.res_count   (res_count)
	);

	assign push_count = item_go ? res_count : 2'd0;

	// result queue parts the two sides
	tcc_out_fifo u_out_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_count (push_count),
		.push0      (res0),
		.push1      (res1),
		.pop        (m_tvalid && m_tready),
		.head       (head),
		.head_valid (head_valid),
		.room2      (room2)
	);

	assign m_tvalid = head_valid;
	assign m_tuser  = head.kind;
	assign m_tlast  = head.last;
	assign m_tdata  = {1'b0, head.bg, head.fg, head.glyph, head.row, head.col};

endmodule
